// File: rtl/dmreg_pkg.sv
// ----------------------------------------------------------------------------
// dmreg_pkg
// Shared widths, register indexes and fixed-point helpers of the damped modal
// residual energy gradient block.
// ----------------------------------------------------------------------------
package dmreg_pkg;

  localparam int DEF_MAX_MODES  = 64;
  localparam int DEF_MAX_FRAMES = 1024;

  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 31;
  localparam int RES_W    = 48;
  localparam int WIDE_W   = 63;
  localparam int GRAD_W   = 48;
  localparam int FRAME_W  = 10;
  localparam int MODE_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODES     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES    = 3'd6;

  // Operands of the shared multiplier: 64-bit signed values
  typedef logic signed [63:0] s64_t;

  // Saturate a 66-bit signed value to w bits, returned sign-extended to 64
  function automatic s64_t sat_w(input logic signed [65:0] v, input int w);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = (66'sd1 <<< (w - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (v > hi) return hi[63:0];
    if (v < lo) return lo[63:0];
    return v[63:0];
  endfunction

  // Floor of the 128-bit product shifted by 16, saturated to w bits
  function automatic s64_t prod_sat(input logic signed [127:0] p, input int w);
    logic signed [127:0] q;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    q  = p >>> 16;
    hi = (128'sd1 <<< (w - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (q > hi) return hi[63:0];
    if (q < lo) return lo[63:0];
    return q[63:0];
  endfunction

endpackage

// File: rtl/dmreg_if.sv
// ----------------------------------------------------------------------------
// dmreg_if
// Valid/ready channel interfaces for input items, results and config writes.
// ----------------------------------------------------------------------------
interface dmreg_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [31:0]          sample;
  logic [30:0]                 mode_stiffness;
  modport source (output valid, sample, mode_stiffness, input ready);
  modport sink   (input valid, sample, mode_stiffness, output ready);
endinterface

interface dmreg_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [47:0]          gradient_value;
  logic [9:0]                  frame_index;
  logic [5:0]                  mode_index;
  logic                        end_of_run;
  logic                        energy_valid;
  logic [62:0]                 energy;
  modport source (output valid, gradient_value, frame_index, mode_index, end_of_run,
                  energy_valid, energy, input ready);
  modport sink   (input valid, gradient_value, frame_index, mode_index, end_of_run,
                  energy_valid, energy, output ready);
endinterface

interface dmreg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/damped_modal_residual_energy_grad.sv
// ----------------------------------------------------------------------------
// damped_modal_residual_energy_grad
// Streaming residual energy and gradient of a damped modal trajectory.
// ----------------------------------------------------------------------------
// Items arrive mode by mode within a frame. Per-mode history (two samples,
// two residuals) lives in one synchronous memory read in the cycle an item is
// accepted. Each item is worked by a sequencer around one shared two-stage
// multiplier, one product at a time through a multiply and a wait state: 2
// products in the first two frames, 13 in an interior frame and 16 in the last
// frame. The item then passes the write-back state and, from the third frame
// on, the result state, where results are transferred one at a time, each
// when out_ch.ready is high, so an output stall holds the item. Items are
// processed one at a time, so consecutive items of the same mode never
// overlap in the memory. No clearing pass is needed after reset.
module damped_modal_residual_energy_grad #(
  parameter int MAX_MODES  = dmreg_pkg::DEF_MAX_MODES,
  parameter int MAX_FRAMES = dmreg_pkg::DEF_MAX_FRAMES
) (
  input  logic       clk,
  input  logic       rst,
  dmreg_in_if.sink   in_ch,
  dmreg_out_if.source out_ch,
  dmreg_cfg_if.sink  cfg
);

  localparam int MI_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int FP_W = $clog2(MAX_FRAMES + 1);
  localparam int ENT_W = 2 * 32 + 2 * 48;

  // State codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_WAIT = 4'd3;
  localparam logic [3:0] ST_POST = 4'd4;
  localparam logic [3:0] ST_EMIT = 4'd5;

  // Configuration registers
  logic [30:0] step_size, inverse_step, inverse_step_squared, mass_damping, stiffness_damping;
  logic [6:0]  modes_in_use;
  logic [10:0] frames_in_use;

  assign cfg.ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size            <= 31'd65536;
      inverse_step         <= 31'd65536;
      inverse_step_squared <= 31'd65536;
      mass_damping         <= '0;
      stiffness_damping    <= '0;
      modes_in_use         <= 7'd1;
      frames_in_use        <= 11'd3;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        dmreg_pkg::REG_STEP:      step_size            <= cfg.data[30:0];
        dmreg_pkg::REG_INV_STEP:  inverse_step         <= cfg.data[30:0];
        dmreg_pkg::REG_INV_STEP2: inverse_step_squared <= cfg.data[30:0];
        dmreg_pkg::REG_ALPHA:     mass_damping         <= cfg.data[30:0];
        dmreg_pkg::REG_BETA:      stiffness_damping    <= cfg.data[30:0];
        dmreg_pkg::REG_MODES:     modes_in_use         <= cfg.data[6:0];
        dmreg_pkg::REG_FRAMES:    frames_in_use        <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  // Clamped limits
  logic [31:0] nm, nf;
  always_comb begin
    nm = (modes_in_use == 7'd0) ? 32'd1 :
         (32'(modes_in_use) > 32'(MAX_MODES)) ? 32'(MAX_MODES) : 32'(modes_in_use);
    nf = (frames_in_use < 11'd3) ? 32'd3 :
         (32'(frames_in_use) > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : 32'(frames_in_use);
  end

  // Per-mode history memory: {prev_sample, older_sample, prev_res, older_res}
  logic [ENT_W-1:0] hist_mem [MAX_MODES];
  logic [ENT_W-1:0] hist_rd;
  logic             hist_we;
  logic [ENT_W-1:0] hist_wd;

  logic [3:0]   state;
  logic [FP_W-1:0] frame_pos;
  logic [MI_W-1:0] mode_pos;
  logic [62:0]  energy_total;

  logic [MI_W-1:0] m;
  logic [FP_W-1:0] f;
  logic signed [63:0] x, lam;
  logic         last;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) hist_rd <= hist_mem[mode_pos];
    if (hist_we) hist_mem[m] <= hist_wd;
  end

  // Working registers
  dmreg_pkg::s64_t damp, cd, c_next, c_mid, r, v, g0, g1, g2, e_t;
  dmreg_pkg::s64_t prev_s, old_s, rp, ro;
  logic [4:0]  step;
  logic [1:0]  n_out, k_out;

  // Shared multiplier
  dmreg_pkg::s64_t mul_a, mul_b, mul_r;
  logic [6:0]      mul_w;
  logic            mul_go;
  dmreg_mul u_mul (.clk(clk), .start(mul_go), .a(mul_a), .b(mul_b), .width(mul_w),
                   .result(mul_r));

  function automatic dmreg_pkg::s64_t adds(input dmreg_pkg::s64_t a, input dmreg_pkg::s64_t b);
    return dmreg_pkg::sat_w(66'(a) + 66'(b), 63);
  endfunction

  dmreg_pkg::s64_t ih2, hh;
  assign ih2 = 64'(inverse_step_squared);
  assign hh  = 64'(step_size);

  // Operand selection per sequence step
  always_comb begin
    mul_a = '0; mul_b = '0; mul_w = 7'd63;
    case (step)
      5'd0:  begin mul_a = 64'(stiffness_damping); mul_b = lam; end
      5'd1:  begin mul_a = 64'(inverse_step); mul_b = damp; end
      5'd2:  begin mul_a = ih2; mul_b = x - 2 * prev_s + old_s; end
      5'd3:  begin mul_a = cd; mul_b = x - prev_s; end
      5'd4:  begin mul_a = lam; mul_b = prev_s; end
      5'd5:  begin mul_a = r; mul_b = r; mul_w = 7'd64; end
      5'd6:  begin mul_a = hh; mul_b = e_t; mul_w = 7'd64; end
      5'd7:  begin mul_a = hh; mul_b = r; end
      5'd8:  begin mul_a = hh; mul_b = rp; end
      5'd9:  begin mul_a = hh; mul_b = ro; end
      5'd10: begin mul_a = ih2; mul_b = g0; end
      5'd11: begin mul_a = c_mid; mul_b = g1; end
      5'd12: begin mul_a = c_next; mul_b = g2; end
      5'd13: begin mul_a = c_mid; mul_b = g0; end
      5'd14: begin mul_a = c_next; mul_b = g1; end
      5'd15: begin mul_a = c_next; mul_b = g0; end
      default: ;
    endcase
  end

  logic [1:0] wcnt;
  logic signed [47:0] grad [3];
  logic [62:0] energy_out;
  logic [64:0] esum;
  logic        seq_done;

  assign in_ch.ready = !rst && (state == ST_IDLE);
  assign mul_go = (state == ST_MUL);

  // Energy sum and end of the product sequence
  assign esum     = 65'(energy_total) + 65'(mul_r >>> 1);
  assign seq_done = (step == 5'd1 && f < 2) || (step == 5'd12 && !last) || (step == 5'd15);

  // Output channel, selected from the result registers by emit_i
  logic [1:0] emit_i;
  assign out_ch.valid          = (state == ST_EMIT);
  assign out_ch.gradient_value = grad[emit_i];
  assign out_ch.frame_index    = 10'(32'(f) - 32'd2 + 32'(emit_i));
  assign out_ch.mode_index     = 6'(m);
  assign out_ch.end_of_run     = (emit_i == n_out - 2'd1);
  assign out_ch.energy_valid   = out_ch.end_of_run && last && (32'(m) + 1 >= nm);
  assign out_ch.energy         = out_ch.energy_valid ? energy_out : 63'd0;

  assign hist_we = (state == ST_POST);
  assign hist_wd = (f >= 2) ? {x[31:0], prev_s[31:0], r[47:0], rp[47:0]}
                            : {x[31:0], prev_s[31:0], rp[47:0], ro[47:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      frame_pos <= '0;
      mode_pos <= '0;
      energy_total <= '0;
      step <= '0;
      wcnt <= '0;
      emit_i <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          x     <= 64'(in_ch.sample);
          lam   <= 64'(in_ch.mode_stiffness);
          m     <= (32'(mode_pos) < MAX_MODES) ? mode_pos : '0;
          f     <= frame_pos;
          last  <= 32'(frame_pos) + 1 >= nf;
          step  <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          prev_s <= 64'($signed(hist_rd[159:128]));
          old_s  <= 64'($signed(hist_rd[127:96]));
          rp     <= 64'($signed(hist_rd[95:48]));
          ro     <= 64'($signed(hist_rd[47:0]));
          state  <= ST_MUL;
        end
        ST_MUL: begin wcnt <= 2'd0; state <= ST_WAIT; end
        ST_WAIT: begin
          wcnt <= wcnt + 2'd1;
          if (wcnt == 2'd1) begin
            state <= seq_done ? ST_POST : ST_MUL;
            step  <= step + 5'd1;
            case (step)
              5'd0: damp <= dmreg_pkg::sat_w(66'(64'(mass_damping)) + 66'(mul_r), 48);
              5'd1: begin
                cd <= mul_r;
                c_next <= adds(ih2, mul_r);
                c_mid <= adds(adds(-2 * ih2, -mul_r), lam);
              end
              5'd2: v <= mul_r;
              5'd3: v <= adds(v, mul_r);
              5'd4: r <= dmreg_pkg::sat_w(66'(adds(v, mul_r)), 48);
              5'd5: e_t <= mul_r;
              5'd6: begin
                energy_total <= (esum > 65'h7fff_ffff_ffff_ffff) ? 63'h7fff_ffff_ffff_ffff
                                                                   : esum[62:0];
              end
              5'd7: g0 <= mul_r;
              5'd8: g1 <= mul_r;
              5'd9: g2 <= mul_r;
              5'd10: v <= mul_r;
              5'd11: if (f >= 3) v <= adds(v, mul_r);
              5'd12: begin
                grad[0] <= 48'(dmreg_pkg::sat_w(66'((f >= 4) ? adds(v, mul_r) : v), 48));
              end
              5'd13: v <= mul_r;
              5'd14: grad[1] <= 48'(dmreg_pkg::sat_w(66'((f >= 3) ? adds(v, mul_r) : v), 48));
              default: begin
                grad[2] <= 48'(dmreg_pkg::sat_w(66'(mul_r), 48));
              end
            endcase
          end
        end
        ST_POST: begin
          n_out  <= (f < 2) ? 2'd0 : (last ? 2'd3 : 2'd1);
          energy_out <= energy_total;
          emit_i <= '0;
          if (32'(m) + 1 >= nm) begin
            mode_pos <= '0;
            frame_pos <= last ? '0 : f + 1'b1;
            if (last && f >= 2) energy_total <= '0;
          end else begin
            mode_pos <= m + 1'b1;
          end
          state <= (f < 2) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: if (out_ch.ready) begin
          emit_i <= emit_i + 2'd1;
          if (emit_i == n_out - 2'd1) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign k_out = n_out;

  // Assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (k_out == 2'd1 || k_out == 2'd3)) else $error("bad result count");
  a_energy_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.energy_valid |-> out_ch.end_of_run) else $error("energy not last");

endmodule

// File: rtl/dmreg_mul.sv
// ----------------------------------------------------------------------------
// dmreg_mul
// Registered 64x64 fixed-point multiplier: four 32x32 partial products are
// registered, then combined; result is floor(a*b/2^16) saturated to w bits.
// ----------------------------------------------------------------------------
module dmreg_mul (
  input  logic                   clk,
  input  logic                   start,
  input  dmreg_pkg::s64_t        a,
  input  dmreg_pkg::s64_t        b,
  input  logic [6:0]             width,
  output dmreg_pkg::s64_t        result
);

  logic        neg;
  logic [63:0] ua;
  logic [63:0] ub;
  logic [63:0] p00, p01, p10, p11;
  logic        neg_q;
  logic [6:0]  width_q;
  logic [127:0] mag;
  logic signed [127:0] prod;

  assign neg = a[63] ^ b[63];
  assign ua  = a[63] ? 64'(-a) : 64'(a);
  assign ub  = b[63] ? 64'(-b) : 64'(b);

  // Stage 1: register partial products
  always_ff @(posedge clk) begin
    if (start) begin
      p00     <= ua[31:0]  * ub[31:0];
      p01     <= ua[31:0]  * ub[63:32];
      p10     <= ua[63:32] * ub[31:0];
      p11     <= ua[63:32] * ub[63:32];
      neg_q   <= neg;
      width_q <= width;
    end
  end

  // Stage 2: combine, restore sign, shift and saturate
  always_comb begin
    mag  = {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32) + ({p11, 64'd0});
    prod = neg_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    result <= dmreg_pkg::prod_sat(prod, int'(width_q));
  end

endmodule
